>>> design/mwq_pkg.sv
// Shared types, constants and helpers for the multi-window queue dispatcher.
package mwq_pkg;

    localparam int TIME_W     = 16;
    localparam int SVC_W      = 10;
    localparam int CNT_CFG_W  = 5;
    localparam int MIN_CFG_W  = 11;
    localparam int CFG_DATA_W = 11;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_WINDOWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_CAPACITY = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_MINUTE    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_MINUTE   = 3'd3;

    localparam logic [CNT_CFG_W-1:0] RST_NUM_WINDOWS    = 5'd2;
    localparam logic [CNT_CFG_W-1:0] RST_QUEUE_CAPACITY = 5'd2;
    localparam logic [MIN_CFG_W-1:0] RST_OPEN_MINUTE    = 11'd480;
    localparam logic [MIN_CFG_W-1:0] RST_CLOSE_MINUTE   = 11'd1020;

    typedef struct packed {
        logic [TIME_W-1:0] end_t;
        logic [TIME_W-1:0] pop_t;
    } time_entry_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

endpackage

>>> design/multi_window_queue_dispatcher_top.sv
// Top level of the multi-window queue dispatcher: control sequencer and state memories.
//
// Usage:
//   Input channel (in_valid / in_stall / service_time) takes one job per item.
//   Output channel (out_valid / out_stall / finish_minute, server_index, refused)
//   returns exactly one item per job, in arrival order.
//   Config port (cfg_we / cfg_index / cfg_data) writes num_windows (0),
//   queue_capacity (1), open_minute (2), close_minute (3); write only when idle.
//   Writing 0..2 restarts dispatch: queues empty, all servers at open_minute.
// Sequence:
//   While queues fill, a job is accepted, reads the time memory, then hands on its result.
//   Once full, a job goes through the earliest-head search, which reads one server's
//   pop time from the time memory per cycle, then a state that pops/pushes the queue
//   memory and one that writes the updated times back.
//   in_stall is high from acceptance until the result is handed to the output
//   register. The output register lets the next job start while a result waits;
//   a stalled receiver holds the result and, once a new one is ready, the block.
// Reset: server times read as open_minute through per-server valid bits, so no
//   clearing pass is needed; the queue memory is never read before it is written.
module multi_window_queue_dispatcher_top
    import mwq_pkg::*;
#(
    parameter int MAX_SERVERS = 16,
    parameter int MAX_QUEUE   = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [SVC_W-1:0]      service_time,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [TIME_W-1:0]     finish_minute,
    output logic [3:0]            server_index,
    output logic                  refused
);

    localparam int SW   = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
    localparam int QW   = (MAX_QUEUE > 1) ? $clog2(MAX_QUEUE) : 1;
    localparam int NW_W = SW + 1;
    localparam int MW   = QW + 1;
    localparam int QD   = MAX_SERVERS * MAX_QUEUE;
    localparam int AW   = (QD > 1) ? $clog2(QD) : 1;
    localparam int JW   = $clog2(QD + 1);
    localparam int EW   = $bits(time_entry_t);

    typedef enum logic [2:0] {S_IDLE, S_FILL, S_SCAN, S_POP, S_UPD, S_DONE} state_t;

    state_t               state_reg;
    logic [CNT_CFG_W-1:0] nw_reg;
    logic [CNT_CFG_W-1:0] qc_reg;
    logic [MIN_CFG_W-1:0] open_reg;
    logic [MIN_CFG_W-1:0] close_reg;
    logic [SVC_W-1:0]     t_reg;
    logic [SW-1:0]        cnt_reg;
    logic [SW-1:0]        sel_reg;
    logic [SW-1:0]        rr_reg;
    logic [JW-1:0]        jobs_reg;
    logic [TIME_W-1:0]    min_reg;
    logic [TIME_W-1:0]    sel_end_reg;
    logic [TIME_W-1:0]    fin_reg;
    logic                 ref_reg;
    logic                 fwd_reg;
    logic [QW-1:0]        head_reg [MAX_SERVERS];
    logic [QW-1:0]        tail_reg [MAX_SERVERS];
    logic [MAX_SERVERS-1:0] valid_reg;
    logic                 out_valid_reg;
    logic [TIME_W-1:0]    out_fin_reg;
    logic [3:0]           out_srv_reg;
    logic                 out_ref_reg;

    logic [NW_W-1:0]      n_eff;
    logic [MW-1:0]        m_eff;
    logic [JW-1:0]        fill_cnt;
    logic                 fill_phase;
    logic                 first_round;
    logic                 in_accept;
    logic [TIME_W-1:0]    open16;
    logic [TIME_W-1:0]    close16;
    logic [TIME_W-1:0]    t16;

    logic                 t_we;
    logic [SW-1:0]        t_waddr;
    time_entry_t          t_wdata;
    logic [SW-1:0]        t_raddr;
    logic [EW-1:0]        t_rdata_raw;
    time_entry_t          t_rdata;
    logic [SW-1:0]        rd_idx;
    logic [TIME_W-1:0]    cur_end;
    logic [TIME_W-1:0]    cur_pop;
    logic [TIME_W-1:0]    fill_finish;

    logic                 q_we;
    logic [AW-1:0]        q_waddr;
    logic [AW-1:0]        q_raddr;
    logic [SVC_W-1:0]     q_rdata;
    logic [SVC_W-1:0]     q_head_val;
    logic [TIME_W-1:0]    pop_new;
    logic [QW-1:0]        sel_head_inc;
    logic [QW-1:0]        sel_tail_inc;
    logic [QW-1:0]        rr_tail_inc;
    logic [SW-1:0]        rr_inc;

    function automatic logic [QW-1:0] ptr_inc(input logic [QW-1:0] p);
        return (p == QW'(MAX_QUEUE - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] q_addr(input logic [SW-1:0] s,
                                             input logic [QW-1:0] p);
        return AW'(s) * AW'(MAX_QUEUE) + AW'(p);
    endfunction

    always_comb
    begin
        if (nw_reg == '0)
            n_eff = NW_W'(1);
        else if (32'(nw_reg) > 32'(MAX_SERVERS))
            n_eff = NW_W'(MAX_SERVERS);
        else
            n_eff = NW_W'(nw_reg);

        if (qc_reg == '0)
            m_eff = MW'(1);
        else if (32'(qc_reg) > 32'(MAX_QUEUE))
            m_eff = MW'(MAX_QUEUE);
        else
            m_eff = MW'(qc_reg);
    end

    assign fill_cnt    = JW'(n_eff) * JW'(m_eff);
    assign fill_phase  = jobs_reg < fill_cnt;
    assign first_round = jobs_reg < JW'(n_eff);
    assign in_stall    = (state_reg != S_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign open16      = {{(TIME_W - MIN_CFG_W){1'b0}}, open_reg};
    assign close16     = {{(TIME_W - MIN_CFG_W){1'b0}}, close_reg};
    assign t16         = {{(TIME_W - SVC_W){1'b0}}, t_reg};

    assign t_rdata     = time_entry_t'(t_rdata_raw);
    assign rd_idx      = (state_reg == S_FILL) ? rr_reg : cnt_reg;
    assign cur_end     = valid_reg[rd_idx] ? t_rdata.end_t : open16;
    assign cur_pop     = valid_reg[rd_idx] ? t_rdata.pop_t : open16;
    assign fill_finish = sat_add(cur_end, t16);

    assign sel_head_inc = ptr_inc(head_reg[sel_reg]);
    assign sel_tail_inc = ptr_inc(tail_reg[sel_reg]);
    assign rr_tail_inc  = ptr_inc(tail_reg[rr_reg]);
    assign rr_inc       = (NW_W'(rr_reg) + 1'b1 == n_eff) ? '0 : rr_reg + 1'b1;
    assign q_head_val   = fwd_reg ? t_reg : q_rdata;
    assign pop_new      = sat_add(min_reg, {{(TIME_W - SVC_W){1'b0}}, q_head_val});

    always_comb
    begin
        case (state_reg)
            S_IDLE:  t_raddr = fill_phase ? rr_reg : '0;
            S_SCAN:  t_raddr = cnt_reg + 1'b1;
            default: t_raddr = '0;
        endcase
    end

    always_comb
    begin
        t_we    = 1'b0;
        t_waddr = sel_reg;
        t_wdata = '{end_t: fin_reg, pop_t: pop_new};
        q_we    = 1'b0;
        q_waddr = q_addr(sel_reg, tail_reg[sel_reg]);
        q_raddr = q_addr(sel_reg, sel_head_inc);
        case (state_reg)
            S_FILL:
            begin
                t_we    = 1'b1;
                t_waddr = rr_reg;
                t_wdata = '{end_t: fill_finish,
                            pop_t: first_round ? fill_finish : cur_pop};
                q_we    = 1'b1;
                q_waddr = q_addr(rr_reg, tail_reg[rr_reg]);
            end
            S_POP:
            begin
                q_we = 1'b1;
            end
            S_UPD:
            begin
                t_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    mwq_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_SERVERS)
    ) u_time_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (t_waddr),
        .wdata (EW'(t_wdata)),
        .raddr (t_raddr),
        .rdata (t_rdata_raw)
    );

    mwq_ram #(
        .WIDTH (SVC_W),
        .DEPTH (QD)
    ) u_queue_ram (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (t_reg),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nw_reg        <= RST_NUM_WINDOWS;
            qc_reg        <= RST_QUEUE_CAPACITY;
            open_reg      <= RST_OPEN_MINUTE;
            close_reg     <= RST_CLOSE_MINUTE;
            t_reg         <= '0;
            cnt_reg       <= '0;
            sel_reg       <= '0;
            rr_reg        <= '0;
            jobs_reg      <= '0;
            min_reg       <= '0;
            sel_end_reg   <= '0;
            fin_reg       <= '0;
            ref_reg       <= 1'b0;
            fwd_reg       <= 1'b0;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_fin_reg   <= '0;
            out_srv_reg   <= '0;
            out_ref_reg   <= 1'b0;
            for (int i = 0; i < MAX_SERVERS; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_NUM_WINDOWS, CFG_QUEUE_CAPACITY, CFG_OPEN_MINUTE:
                    begin
                        if (cfg_index == CFG_NUM_WINDOWS)
                            nw_reg <= cfg_data[CNT_CFG_W-1:0];
                        if (cfg_index == CFG_QUEUE_CAPACITY)
                            qc_reg <= cfg_data[CNT_CFG_W-1:0];
                        if (cfg_index == CFG_OPEN_MINUTE)
                            open_reg <= cfg_data;
                        valid_reg <= '0;
                        rr_reg    <= '0;
                        jobs_reg  <= '0;
                        for (int i = 0; i < MAX_SERVERS; i++)
                        begin
                            head_reg[i] <= '0;
                            tail_reg[i] <= '0;
                        end
                    end
                    CFG_CLOSE_MINUTE:
                    begin
                        close_reg <= cfg_data;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (out_valid_reg && !out_stall && state_reg != S_DONE)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        t_reg   <= service_time;
                        cnt_reg <= '0;
                        state_reg <= fill_phase ? S_FILL : S_SCAN;
                    end
                end
                S_FILL:
                begin
                    fin_reg          <= fill_finish;
                    ref_reg          <= (cur_end >= close16);
                    sel_reg          <= rr_reg;
                    tail_reg[rr_reg] <= rr_tail_inc;
                    valid_reg[rr_reg] <= 1'b1;
                    jobs_reg         <= jobs_reg + 1'b1;
                    rr_reg           <= rr_inc;
                    state_reg        <= S_DONE;
                end
                S_SCAN:
                begin
                    if (cnt_reg == '0 || cur_pop < min_reg)
                    begin
                        min_reg     <= cur_pop;
                        sel_reg     <= cnt_reg;
                        sel_end_reg <= cur_end;
                    end
                    if (NW_W'(cnt_reg) + 1'b1 == n_eff)
                        state_reg <= S_POP;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                S_POP:
                begin
                    head_reg[sel_reg] <= sel_head_inc;
                    tail_reg[sel_reg] <= sel_tail_inc;
                    fwd_reg           <= (sel_head_inc == tail_reg[sel_reg]);
                    fin_reg           <= sat_add(sel_end_reg, t16);
                    ref_reg           <= (sel_end_reg >= close16);
                    state_reg         <= S_UPD;
                end
                S_UPD:
                begin
                    valid_reg[sel_reg] <= 1'b1;
                    state_reg          <= S_DONE;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || !out_stall)
                    begin
                        out_valid_reg <= 1'b1;
                        out_fin_reg   <= fin_reg;
                        out_srv_reg   <= 4'(sel_reg);
                        out_ref_reg   <= ref_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid     = out_valid_reg;
    assign finish_minute = out_fin_reg;
    assign server_index  = out_srv_reg;
    assign refused       = out_ref_reg;

    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (NW_W'(cnt_reg) < n_eff))
        else $error("scan index beyond active servers");

    a_sel_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP || state_reg == S_UPD) |-> (NW_W'(sel_reg) < n_eff))
        else $error("selected server beyond active servers");

    a_jobs_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        jobs_reg <= fill_cnt)
        else $error("job count passed fill count");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("block did not go busy after taking an item");

    a_scan_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE && in_accept && !fill_phase) |=> (state_reg == S_SCAN))
        else $error("full-queue job did not start the search");

endmodule

>>> design/mwq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mwq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
